### src/sfl_pkg.sv
// Package of the slot free list and ready queue: command and outcome codes, word types.
`default_nettype none
package sfl_pkg;

  localparam int unsigned SlotsDefault = 1024;
  localparam int unsigned SlotW        = 10;
  localparam int unsigned CmdW         = 3;
  localparam int unsigned OutcomeW     = 2;

  localparam logic [CmdW-1:0] CMD_ALLOC   = 3'd0;
  localparam logic [CmdW-1:0] CMD_READY   = 3'd1;
  localparam logic [CmdW-1:0] CMD_ERROR   = 3'd2;
  localparam logic [CmdW-1:0] CMD_FETCH   = 3'd3;
  localparam logic [CmdW-1:0] CMD_RELEASE = 3'd4;

  localparam logic [OutcomeW-1:0] OUT_DONE    = 2'd0;
  localparam logic [OutcomeW-1:0] OUT_NO_IDLE = 2'd1;
  localparam logic [OutcomeW-1:0] OUT_EMPTY   = 2'd2;
  localparam logic [OutcomeW-1:0] OUT_QUEUED  = 2'd3;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [SlotW-1:0] slot;
    logic             retain;
  } sfl_in_t;

  typedef struct packed {
    logic [OutcomeW-1:0] outcome;
    logic [SlotW-1:0]    slot_out;
  } sfl_out_t;

endpackage
`default_nettype wire

### src/sfl_ram.sv
// Simple dual-port synchronous RAM with one write port and one registered read port.
`default_nettype none
module sfl_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 11,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

### src/slot_free_list_and_ready_queue.sv
// Top level of the slot free list and ready queue: command sequencer around two RAMs.
`default_nettype none
// Usage
// One command word enters on in_i and is accepted at a rising edge where start_i is high
// and busy_o is low. Every command gives exactly one result word on result_o, marked by
// done_o for exactly one cycle; the receiver cannot stall, so it must take the word then.
// The idle stack and the ready FIFO are threaded through one link RAM, and the queued
// flags live in a second RAM. Both RAMs have a registered read port.
// Timing: the accept edge launches the RAM reads, the following execute cycle computes
// and writes back, and done_o is high in the cycle after that. A new command may be
// accepted in that same result cycle, but not while a command is still executing.
// A ready command that appends behind an existing tail needs a second link write and
// holds busy_o through the extra ST_LINK state. The spacing of commands is set by the
// registered read of the link RAM, whose output decides the next stack or FIFO head.
// Reset: after rst_ni is released the block runs a clearing pass that writes link entry i
// with i+1 and clears every queued flag; busy_o stays high meanwhile.
// After that the idle stack holds every slot and the ready FIFO is empty.
module slot_free_list_and_ready_queue #(
  parameter int unsigned SLOTS = sfl_pkg::SlotsDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire sfl_pkg::sfl_in_t in_i,
  output logic                  busy_o,
  output logic                  done_o,
  output sfl_pkg::sfl_out_t     result_o
);

  // Index width covers slot numbers; link width also holds the null value SLOTS.
  localparam int unsigned IdxW  = $clog2(SLOTS);
  localparam int unsigned LinkW = $clog2(SLOTS + 1);
  localparam logic [LinkW-1:0] NullLink = LinkW'(SLOTS);
  localparam logic [IdxW-1:0]  LastIdx  = IdxW'(SLOTS - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;
  localparam logic [1:0] ST_LINK  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [IdxW-1:0] clr_q, clr_d;

  // List pointers, raw link values where anything at or above SLOTS counts as null.
  logic [LinkW-1:0] top_q, top_d;
  logic [LinkW-1:0] head_q, head_d;
  logic [LinkW-1:0] tail_q, tail_d;

  // The command being executed and the old tail for a deferred append.
  logic [sfl_pkg::CmdW-1:0]  cmd_q;
  logic [sfl_pkg::SlotW-1:0] slot_q;
  logic                      keep_q;
  logic [IdxW-1:0]           tail_wr_q, tail_wr_d;

  logic              done_q, done_d;
  sfl_pkg::sfl_out_t res_q, res_d;

  logic             accept;
  logic             in_range;
  logic [IdxW-1:0]  slot_idx;
  logic [LinkW-1:0] slot_link;

  logic             link_we, flag_we;
  logic [IdxW-1:0]  link_waddr, flag_waddr, link_raddr;
  logic [LinkW-1:0] link_wdata, link_rdata;
  logic             flag_wdata, flag_rdata;

  function automatic logic is_null(input logic [LinkW-1:0] p);
    return p >= NullLink;
  endfunction

  assign accept    = start_i && !busy_o;
  assign slot_idx  = IdxW'(slot_q);
  assign slot_link = LinkW'(slot_q);
  assign in_range  = 32'(slot_q) < 32'(SLOTS);

  // A fetch reads the link behind the FIFO head, everything else the one behind the top.
  assign link_raddr = (in_i.command == sfl_pkg::CMD_FETCH) ? IdxW'(head_q) : IdxW'(top_q);

  sfl_ram #(
    .Depth(SLOTS),
    .Width(LinkW)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (link_we),
    .waddr_i(link_waddr),
    .wdata_i(link_wdata),
    .re_i   (accept),
    .raddr_i(link_raddr),
    .rdata_o(link_rdata)
  );

  sfl_ram #(
    .Depth(SLOTS),
    .Width(1)
  ) u_flag_ram (
    .clk_i  (clk_i),
    .we_i   (flag_we),
    .waddr_i(flag_waddr),
    .wdata_i(flag_wdata),
    .re_i   (accept),
    .raddr_i(IdxW'(in_i.slot)),
    .rdata_o(flag_rdata)
  );

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    top_d      = top_q;
    head_d     = head_q;
    tail_d     = tail_q;
    tail_wr_d  = tail_wr_q;
    done_d     = 1'b0;
    res_d      = res_q;
    link_we    = 1'b0;
    link_waddr = slot_idx;
    link_wdata = NullLink;
    flag_we    = 1'b0;
    flag_waddr = slot_idx;
    flag_wdata = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        // Clearing pass: link entry i gets i+1 and each queued flag is cleared.
        link_we    = 1'b1;
        link_waddr = clr_q;
        link_wdata = LinkW'(clr_q) + LinkW'(1);
        flag_we    = 1'b1;
        flag_waddr = clr_q;
        if (clr_q == LastIdx) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + IdxW'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d        = ST_IDLE;
        done_d         = 1'b1;
        res_d.outcome  = sfl_pkg::OUT_DONE;
        res_d.slot_out = slot_q;
        case (cmd_q)
          sfl_pkg::CMD_ALLOC: begin
            if (is_null(top_q)) begin
              res_d.outcome = sfl_pkg::OUT_NO_IDLE;
            end else begin
              top_d          = link_rdata;
              link_we        = 1'b1;
              link_waddr     = IdxW'(top_q);
              link_wdata     = NullLink;
              flag_we        = 1'b1;
              flag_waddr     = IdxW'(top_q);
              flag_wdata     = 1'b0;
              res_d.slot_out = sfl_pkg::SlotW'(top_q);
            end
          end
          sfl_pkg::CMD_READY: begin
            if (in_range) begin
              if (flag_rdata) begin
                res_d.outcome = sfl_pkg::OUT_QUEUED;
              end else begin
                flag_we    = 1'b1;
                flag_wdata = 1'b1;
                link_we    = 1'b1;
                link_wdata = NullLink;
                if (is_null(head_q)) begin
                  head_d = slot_link;
                end else if (!is_null(tail_q)) begin
                  // The old tail still has to point at the new slot: second write.
                  tail_wr_d = IdxW'(tail_q);
                  state_d   = ST_LINK;
                end
                tail_d = slot_link;
              end
            end
          end
          sfl_pkg::CMD_ERROR: begin
            if (in_range) begin
              link_we    = 1'b1;
              link_wdata = top_q;
              top_d      = slot_link;
            end
          end
          sfl_pkg::CMD_FETCH: begin
            if (is_null(head_q)) begin
              res_d.outcome = sfl_pkg::OUT_EMPTY;
            end else begin
              head_d = link_rdata;
              if (is_null(link_rdata)) begin
                tail_d = NullLink;
              end
              res_d.slot_out = sfl_pkg::SlotW'(head_q);
            end
          end
          sfl_pkg::CMD_RELEASE: begin
            if (in_range) begin
              if (keep_q) begin
                flag_we    = 1'b1;
                flag_wdata = 1'b0;
              end else begin
                link_we    = 1'b1;
                link_wdata = top_q;
                top_d      = slot_link;
              end
            end
          end
          default: begin
          end
        endcase
      end
      ST_LINK: begin
        state_d    = ST_IDLE;
        link_we    = 1'b1;
        link_waddr = tail_wr_q;
        link_wdata = slot_link;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      top_q   <= '0;
      head_q  <= NullLink;
      tail_q  <= NullLink;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      top_q   <= top_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= in_i.command;
      slot_q <= in_i.slot;
      keep_q <= in_i.retain;
    end
    tail_wr_q <= tail_wr_d;
    res_q     <= res_d;
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

  // A result word only ever follows an execute cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == ST_EXEC)
    else $error("result word without an execute cycle");

  // An accepted command keeps the block busy for its execute cycle, with no result yet.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o && !done_o)
    else $error("accepted command did not enter execution");

  // The deferred tail write belongs to a ready command that completed normally.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LINK) |-> done_o && result_o.outcome == sfl_pkg::OUT_DONE
      && cmd_q == sfl_pkg::CMD_READY)
    else $error("tail link write outside a ready append");

  // No result word appears during the clearing pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !done_o)
    else $error("result word during the clearing pass");

endmodule
`default_nettype wire
